>>> rtl/rde_pkg.sv
// Package for the radix digit encoder: payload structs, sequencer states,
// field widths and fixed constants. No dependencies.
package rde_pkg;

    localparam int MAG_W          = 63;
    localparam int DIV_W          = 64;   // magnitude padded to a whole number of steps
    localparam int BITS_PER_STEP  = 8;
    localparam int STEPS_PER_DIGIT = DIV_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(STEPS_PER_DIGIT);
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 4;
    localparam int SYM_W          = 8;
    localparam int SYMTAB_W       = 64;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 5;
    localparam int DEF_MAX_RADIX  = 16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [SYM_W-1:0]   MINUS_SYM   = 8'h2D;

    typedef enum logic [1:0] {
        REG_RADIX   = 2'd0,
        REG_SYM_LOW = 2'd1,
        REG_SYM_HIGH = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             negative;
    } req_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } rsp_item_t;

endpackage

>>> rtl/radix_digit_encoder.sv
// Radix digit encoder top level: APB register file, divide sequencer and
// output register. Depends on rde_pkg.
//
// Usage: a request item (magnitude, negative) is taken on req_valid/req_ready.
// The block then emits the digits of the magnitude in the configured radix,
// least significant first, one rsp item per symbol on rsp_valid/rsp_ready,
// each digit mapped through the symbol table. A zero magnitude gives the
// digit-0 symbol alone; otherwise a set negative flag appends 0x2D. The
// final symbol of a value carries last.
// Timing: each digit comes from a shared 8-bit-per-cycle restoring divider,
// then waits in the output register. The longest value, in radix 2, has 63
// digits plus a sign. After the final symbol the sequencer returns to idle
// before the next request is taken. One item is in work at a time.
// A stalled receiver holds the output register; the divider waits with it.
// Reset: radix 10, symbol tables zero, sequencer idle, no rsp pending.
// Registers: radix at 0x00, symbols_low at 0x08, symbols_high at 0x10.
module radix_digit_encoder
    import rde_pkg::*;
#(
    parameter int MAX_RADIX = DEF_MAX_RADIX
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_item_t             rsp_data
);

    localparam int REM_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int CMP_W = REM_W + 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_DIGIT - 1);

    // configuration
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic [SYMTAB_W-1:0] sym_lo_reg, sym_lo_next;
    logic [SYMTAB_W-1:0] sym_hi_reg, sym_hi_next;
    reg_idx_t            reg_idx;
    logic                cfg_wr;

    // sequencer and datapath
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                sign_reg, sign_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_reg, last_next;

    logic [CMP_W-1:0]    eff_radix;
    logic [DIV_W-1:0]    div_step;
    logic [REM_W-1:0]    rem_step;
    logic [SYM_W-1:0]    digit_sym;
    logic                req_fire, rsp_fire;
    logic                step_done;

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        radix_next  = radix_reg;
        sym_lo_next = sym_lo_reg;
        sym_hi_next = sym_hi_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_RADIX:    radix_next  = pwdata[RADIX_W-1:0];
                REG_SYM_LOW:  sym_lo_next = pwdata;
                REG_SYM_HIGH: sym_hi_next = pwdata;
                REG_NONE:     ;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RADIX:    prdata = {{(APB_DATA_W-RADIX_W){1'b0}}, radix_reg};
            REG_SYM_LOW:  prdata = sym_lo_reg;
            REG_SYM_HIGH: prdata = sym_hi_reg;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= RADIX_RESET;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
        end
        else
        begin
            radix_reg  <= radix_next;
            sym_lo_reg <= sym_lo_next;
            sym_hi_reg <= sym_hi_next;
        end
    end

    // radix clamped to 2..MAX_RADIX
    always_comb
    begin
        priority if (radix_reg < RADIX_W'(2))
            eff_radix = CMP_W'(2);
        else if (radix_reg > RADIX_W'(MAX_RADIX))
            eff_radix = CMP_W'(MAX_RADIX);
        else
            eff_radix = radix_reg[CMP_W-1:0];
    end

    // ---------------- shared divider ----------------
    // Restoring division, BITS_PER_STEP quotient bits per cycle, MSB first.
    always_comb
    begin
        logic [CMP_W-1:0] partial;
        logic             qbit;
        div_step = div_reg;
        rem_step = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            partial = {rem_step, div_step[DIV_W-1]};
            qbit    = (partial >= eff_radix);
            if (qbit)
                partial = partial - eff_radix;
            rem_step = partial[REM_W-1:0];
            div_step = {div_step[DIV_W-2:0], qbit};
        end
    end

    // symbol lookup for the digit just produced (or digit 0 on a zero input)
    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        d = (state_reg == ST_DIV) ? DIGIT_W'(rem_step) : '0;
        if (d[DIGIT_W-1])
            digit_sym = sym_hi_reg[{d[DIGIT_W-2:0], 3'b000} +: SYM_W];
        else
            digit_sym = sym_lo_reg[{d[DIGIT_W-2:0], 3'b000} +: SYM_W];
    end

    assign req_fire  = req_valid && req_ready;
    assign rsp_fire  = rsp_valid && rsp_ready;
    assign step_done = (step_reg == LAST_STEP);

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_fire)
                    state_next = (req_data.magnitude == '0) ? ST_OUT : ST_DIV;
            ST_DIV:
                if (step_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (rsp_fire)
                begin
                    priority if (last_reg)
                        state_next = ST_IDLE;
                    else if (div_reg == '0)
                        state_next = ST_OUT;   // minus sign still to go
                    else
                        state_next = ST_DIV;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_OUT:  rsp_valid = 1'b1;
            ST_DIV:  ;
            default: ;
        endcase
    end

    assign rsp_data.symbol = sym_reg;
    assign rsp_data.last   = last_reg;

    // ---------------- datapath next values ----------------
    always_comb
    begin
        step_next = step_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        sign_next = sign_reg;
        sym_next  = sym_reg;
        last_next = last_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_fire)
                begin
                    div_next  = {1'b0, req_data.magnitude};
                    rem_next  = '0;
                    step_next = '0;
                    sign_next = req_data.negative;
                    sym_next  = digit_sym;
                    last_next = 1'b1;
                end
            ST_DIV:
            begin
                div_next  = div_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_done)
                begin
                    sym_next  = digit_sym;
                    last_next = (div_step == '0) && !sign_reg;
                end
            end
            ST_OUT:
                if (rsp_fire && !last_reg)
                begin
                    if (div_reg == '0)
                    begin
                        sym_next  = MINUS_SYM;
                        last_next = 1'b1;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        rem_next  = '0;
                        step_next = '0;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            div_reg   <= '0;
            rem_reg   <= '0;
            sign_reg  <= 1'b0;
            sym_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            div_reg   <= div_next;
            rem_reg   <= rem_next;
            sign_reg  <= sign_next;
            sym_reg   <= sym_next;
            last_reg  <= last_next;
        end
    end

    // ---------------- assertions ----------------
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request and response sides active together");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("divide step counter running outside divide");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ({1'b0, rem_reg} < eff_radix))
        else $error("remainder not below radix");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire && rsp_data.last) |=> req_ready)
        else $error("block not ready after final symbol");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("ready right after accepting an item");

endmodule

>>> tb/tb_radix_digit_encoder.sv
// Self-checking testbench for radix_digit_encoder: directed and random values,
// register writes over APB, random idling and long output stalls.
// Depends on rde_pkg and the radix_digit_encoder RTL.
module tb_radix_digit_encoder
    import rde_pkg::*;
;

    localparam int IDLE_LIMIT = 4000;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam logic [SYMTAB_W-1:0] ASCII_LOW  = 64'h3736353433323130;
    localparam logic [SYMTAB_W-1:0] ASCII_HIGH = 64'h4645444342413938;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_item_t             req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_item_t             rsp_data;

    // shadow copy of the register file
    logic [RADIX_W-1:0]  cfg_radix = RADIX_RESET;
    logic [SYMTAB_W-1:0] cfg_sym_low = '0;
    logic [SYMTAB_W-1:0] cfg_sym_high = '0;

    rsp_item_t pending_symbols[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off_request = 0;
    int        hold_left = 0;
    int        idle_cycles = 0;

    radix_digit_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

    always #1 clk = ~clk;

    function automatic logic [SYM_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
        if (d < 8)
            return cfg_sym_low[8*d +: 8];
        return cfg_sym_high[8*(d-8) +: 8];
    endfunction

    // Expected symbols for one value, least significant digit first.
    task automatic predict_symbols(input req_item_t item);
        logic [63:0] q;
        logic [63:0] base;
        logic [63:0] d;
        int          n;
        rsp_item_t   r;
        base = 64'(cfg_radix);
        if (base < 2)
            base = 64'd2;
        if (base > DEF_MAX_RADIX)
            base = 64'(DEF_MAX_RADIX);
        q = {1'b0, item.magnitude};
        n = 0;
        if (q == 0)
        begin
            r.symbol = digit_symbol('0);
            r.last = 1'b1;
            pending_symbols.push_back(r);
        end
        else
        begin
            while (q != 0 && n < 63)
            begin
                d = q % base;
                q = q / base;
                r.symbol = digit_symbol(d[DIGIT_W-1:0]);
                r.last = (q == 0) && !item.negative;
                pending_symbols.push_back(r);
                n++;
            end
            if (item.negative)
            begin
                r.symbol = MINUS_SYM;
                r.last = 1'b1;
                pending_symbols.push_back(r);
            end
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        rsp_item_t exp_item;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected symbol %h last %b", rsp_data.symbol, rsp_data.last);
                errors++;
            end
            else
            begin
                exp_item = pending_symbols.pop_front();
                if (rsp_data.symbol !== exp_item.symbol)
                begin
                    $error("symbol mismatch: expected %h, got %h",
                           exp_item.symbol, rsp_data.symbol);
                    errors++;
                end
                if (rsp_data.last !== exp_item.last)
                begin
                    $error("last mismatch: expected %b, got %b", exp_item.last, rsp_data.last);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_off_request > 0)
        begin
            hold_left = hold_off_request;
            hold_off_request = 0;
        end
        if (hold_left > 0)
        begin
            rsp_ready = 1'b0;
            hold_left--;
        end
        else
        begin
            rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no handshake on any port
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_W'(idx) << 3;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_RADIX:    cfg_radix = value[RADIX_W-1:0];
            REG_SYM_LOW:  cfg_sym_low = value;
            REG_SYM_HIGH: cfg_sym_high = value;
            default:      ;
        endcase
    endtask

    task automatic send_value(input logic [MAG_W-1:0] mag, input logic neg);
        req_item_t item;
        item.magnitude = mag;
        item.negative = neg;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        req_data = item;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_symbols(item);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_symbols.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [MAG_W-1:0] rand_magnitude();
        logic [63:0] w;
        int          kind;
        w = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind < 2)
            w = 64'($urandom_range(0, 40));
        else if (kind > 5 && kind < 9)
            w = w >> $urandom_range(1, 63);
        else if (kind == 9)
            w = $urandom_range(0, 1) ? '1 : '0;
        return w[MAG_W-1:0];
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic randomize_config();
        logic [RADIX_W-1:0] r;
        if ($urandom_range(0, 4) == 0)
            r = RADIX_W'($urandom_range(0, 31));
        else
            r = RADIX_W'($urandom_range(2, DEF_MAX_RADIX));
        write_reg(REG_RADIX, APB_DATA_W'(r));
        write_reg(REG_SYM_LOW, {$urandom, $urandom});
        write_reg(REG_SYM_HIGH, {$urandom, $urandom});
    endtask

    task automatic test_reset_defaults();
        send_value(63'd0, 1'b1);
        send_value(63'd12345, 1'b1);
        send_value(MAG_MAX, 1'b0);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        write_reg(REG_SYM_LOW, ASCII_LOW);
        write_reg(REG_SYM_HIGH, ASCII_HIGH);
        write_reg(REG_RADIX, 64'd16);
        send_value(63'd0, 1'b1);
        send_value(63'd0, 1'b0);
        send_value(MAG_MAX, 1'b0);
        send_value(MAG_MAX, 1'b1);
        send_value(63'd1, 1'b1);
        send_value(63'd15, 1'b0);
        send_value(63'd16, 1'b1);
        send_value(63'd255, 1'b0);
        wait_drained();
        // binary: the longest value, 63 digits plus sign
        write_reg(REG_RADIX, 64'd2);
        send_value(MAG_MAX, 1'b1);
        send_value(63'd1, 1'b0);
        wait_drained();
        // radix below 2 clamps to 2, above the maximum clamps to it
        write_reg(REG_RADIX, 64'd0);
        send_value(63'd5, 1'b1);
        wait_drained();
        write_reg(REG_RADIX, 64'd1);
        send_value(63'd6, 1'b0);
        wait_drained();
        write_reg(REG_RADIX, 64'd17);
        send_value(MAG_MAX, 1'b0);
        wait_drained();
        write_reg(REG_RADIX, '1);
        send_value(63'd255, 1'b1);
        wait_drained();
        write_reg(REG_SYM_LOW, '1);
        write_reg(REG_SYM_HIGH, '1);
        write_reg(REG_RADIX, 64'd16);
        send_value(MAG_MAX, 1'b1);
        wait_drained();
        // write to an unmapped register must change nothing
        write_reg(REG_NONE, {$urandom, $urandom});
        write_reg(REG_RADIX, 64'd10);
        write_reg(REG_SYM_LOW, ASCII_LOW);
        write_reg(REG_SYM_HIGH, ASCII_HIGH);
        write_reg(REG_NONE, '1);
        send_value(63'd123456789, 1'b1);
        wait_drained();
        write_reg(REG_SYM_LOW, '0);
        write_reg(REG_SYM_HIGH, '0);
        send_value(63'd42, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                wait_drained();
                randomize_config();
            end
            send_value(rand_magnitude(), rand_bit());
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_RADIX, 64'd10);
        write_reg(REG_SYM_LOW, ASCII_LOW);
        write_reg(REG_SYM_HIGH, ASCII_HIGH);
        // receiver holds off while several values are offered
        hold_off_request = 300;
        for (int i = 0; i < 6; i++)
            send_value(rand_magnitude(), rand_bit());
        // sender pauses until every symbol is out
        wait_drained();
        recv_stall_pct = 29;
        for (int i = 0; i < 4; i++)
            send_value(rand_magnitude(), rand_bit());
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_directed_cases();
        test_random_traffic(0, 0, 48);
        test_random_traffic(53, 0, 48);
        test_random_traffic(0, 53, 48);
        test_random_traffic(29, 29, 48);
        test_output_backpressure();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_symbols.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/rde_pkg.sv
rtl/radix_digit_encoder.sv
tb/tb_radix_digit_encoder.sv
